// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the scanner RTL.
// Define ASSERT_OFF to compile all assertions out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define CSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define CSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/csscan_pkg.sv =====
// Package for the conserved segment scanner: widths, register indexes and
// the result record. No dependencies.
`timescale 1ns / 1ps

package csscan_pkg;

    localparam int SCORE_BITS = 16;
    localparam int ACC_BITS   = 24;
    localparam int POS_BITS   = 16;
    localparam int THR_BITS   = 23;
    localparam int IDX_BITS   = POS_BITS + 1;

    localparam int CFG_DATA_BITS = (THR_BITS > POS_BITS) ? THR_BITS : POS_BITS;
    localparam int CFG_IDX_BITS  = 1;

    localparam int WIDE_BITS = (ACC_BITS > SCORE_BITS) ? ACC_BITS : SCORE_BITS;
    localparam int SUM_BITS  = ((WIDE_BITS > THR_BITS) ? WIDE_BITS : THR_BITS + 1) + 1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_THRESHOLD = 1'b0,
        CFG_START     = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [POS_BITS-1:0] left;
        logic [IDX_BITS-1:0] right;
        logic                seg_valid;
        logic                done;
    } t_result;

endpackage

// ===== hw/rtl/conserved_segment_scanner_unit.sv =====
// Conserved segment scanner: X-drop maximal-scoring segment scan over a
// stream of column scores. Depends on csscan_pkg and assert_macros.svh.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | in        | i_in_valid/o_in_ready  | column_score, last_column
//  out     | out       | o_out_valid/i_out_ready| segment_left/right/valid, done
//  cfg     | in        | i_cfg_valid/o_cfg_ready| cfg_index, cfg_data
//
// One column per cycle while no result waits on a stalled output; a column is
// held in the input register and its result is then registered for output.
// The score update is one add, clamp and compare from the input register.
// Reset clears all control state and loads the register defaults.
// A stalled result holds the output register; requests that yield no
// result keep flowing, one that yields a result waits for a free slot.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module conserved_segment_scanner_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [csscan_pkg::SCORE_BITS-1:0] i_column_score,
    input  logic                                   i_last_column,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [csscan_pkg::POS_BITS-1:0]        o_segment_left,
    output logic [csscan_pkg::IDX_BITS-1:0]        o_segment_right,
    output logic                                   o_segment_valid,
    output logic                                   o_stream_done,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [csscan_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [csscan_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import csscan_pkg::*;

    localparam logic signed [SUM_BITS-1:0] ACC_MAX_S =
        SUM_BITS'((64'd1 << (ACC_BITS - 1)) - 64'd1);

    logic [THR_BITS-1:0] r_thr;
    logic [POS_BITS-1:0] r_start_pos;

    logic                         r_s1_valid;
    logic signed [SCORE_BITS-1:0] r_s1_score;
    logic                         r_s1_last;

    logic [ACC_BITS-1:0] r_run;
    logic [ACC_BITS-1:0] r_best;
    logic [POS_BITS-1:0] r_seg_start;
    logic [IDX_BITS-1:0] r_seg_end;
    logic [IDX_BITS-1:0] r_idx;

    logic    r_out_valid;
    t_result r_out;

    logic signed [SUM_BITS-1:0] w_score;
    logic signed [SUM_BITS-1:0] w_run;
    logic signed [SUM_BITS-1:0] w_best;
    logic signed [SUM_BITS-1:0] w_thr;
    logic signed [SUM_BITS-1:0] w_sum;
    logic signed [SUM_BITS-1:0] w_clamped;
    logic signed [SUM_BITS-1:0] w_best_upd;
    logic signed [SUM_BITS-1:0] w_run_after;
    logic                       w_start_hit;
    logic                       w_best_hit;
    logic                       w_drop;
    logic                       w_flush_valid;
    logic                       w_emit;
    logic                       w_out_free;
    logic                       w_s1_adv;
    logic [IDX_BITS-1:0]        w_idx_inc;

    logic [ACC_BITS-1:0] n_run;
    logic [ACC_BITS-1:0] n_best;
    logic [POS_BITS-1:0] n_seg_start;
    logic [IDX_BITS-1:0] n_seg_end;
    logic [IDX_BITS-1:0] n_idx;
    t_result             n_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THR_BITS'(1);
            r_start_pos <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_THRESHOLD: r_thr       <= i_cfg_data[THR_BITS-1:0];
                CFG_START:     r_start_pos <= i_cfg_data[POS_BITS-1:0];
                default:       r_thr       <= r_thr;
            endcase
        end
    end

    always_comb begin
        w_score     = SUM_BITS'(r_s1_score);
        w_run       = signed'(SUM_BITS'(r_run));
        w_best      = signed'(SUM_BITS'(r_best));
        w_thr       = signed'(SUM_BITS'(r_thr));
        w_sum       = w_run + w_score;
        w_start_hit = (r_run == '0) && (w_score > 0);

        priority if (w_sum > ACC_MAX_S) begin
            w_clamped = ACC_MAX_S;
        end else if (w_sum < 0) begin
            w_clamped = '0;
        end else begin
            w_clamped = w_sum;
        end

        w_best_hit  = (w_sum >= 0) && (w_clamped >= w_thr) && (w_clamped > w_best);
        w_best_upd  = w_best_hit ? w_clamped : w_best;
        w_idx_inc   = r_idx + IDX_BITS'(1);
        n_seg_start = w_start_hit ? r_idx[POS_BITS-1:0] : r_seg_start;
        n_seg_end   = w_best_hit ? w_idx_inc : r_seg_end;

        w_drop = (w_best_upd > 0) &&
                 ((w_clamped == 0) || (w_clamped < (w_best_upd - w_thr)));
        w_run_after   = w_drop ? '0 : w_clamped;
        w_flush_valid = w_run_after >= w_thr;
        w_emit        = w_drop || r_s1_last;

        n_out.seg_valid = w_drop || w_flush_valid;
        n_out.left      = n_out.seg_valid ? n_seg_start : '0;
        n_out.right     = n_out.seg_valid ? n_seg_end : '0;
        n_out.done      = r_s1_last;

        if (r_s1_last) begin
            n_run       = '0;
            n_best      = '0;
            n_idx       = IDX_BITS'(r_start_pos);
        end else begin
            n_run       = w_run_after[ACC_BITS-1:0];
            n_best      = w_drop ? '0 : w_best_upd[ACC_BITS-1:0];
            n_idx       = w_idx_inc;
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_s1_adv   = r_s1_valid && (!w_emit || w_out_free);
    assign o_in_ready = !r_s1_valid || w_s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_score <= i_column_score;
            r_s1_last  <= i_last_column;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= '0;
            r_best      <= '0;
            r_seg_start <= '0;
            r_seg_end   <= '0;
            r_idx       <= '0;
        end else if (w_s1_adv) begin
            r_run       <= n_run;
            r_best      <= n_best;
            r_seg_start <= r_s1_last ? '0 : n_seg_start;
            r_seg_end   <= r_s1_last ? '0 : n_seg_end;
            r_idx       <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && w_emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_segment_left  = r_out.left;
    assign o_segment_right = r_out.right;
    assign o_segment_valid = r_out.seg_valid;
    assign o_stream_done   = r_out.done;

    `CSS_ASSERT_IMPL(a_run_not_saturated_past_max, i_clk, i_rst_n,
        1'b1, !r_run[ACC_BITS-1] && !r_best[ACC_BITS-1])
    `CSS_ASSERT_NEXT(a_rearm_after_last, i_clk, i_rst_n,
        w_s1_adv && r_s1_last, (r_run == '0) && (r_best == '0) && (r_seg_end == '0))
    `CSS_ASSERT_IMPL(a_marker_is_empty, i_clk, i_rst_n,
        o_out_valid && !o_segment_valid,
        o_stream_done && (o_segment_left == '0) && (o_segment_right == '0))
    `CSS_ASSERT_NEXT(a_stalled_result_kept, i_clk, i_rst_n,
        r_out_valid && !i_out_ready, r_out_valid)
    `CSS_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n,
        w_s1_adv && w_emit, w_out_free)

endmodule
